FILE: design/isots_pkg.sv
// ----------------------------------------------------------------------------
// isots_pkg
// shared types and constants of the iso-8601 utc timestamp parser
// ----------------------------------------------------------------------------
package isots_pkg;

  // parse position, one per expected character, then the tail states
  typedef enum logic [4:0] {
    PH_Y0, PH_Y1, PH_Y2, PH_Y3, PH_DASH1, PH_MO0, PH_MO1, PH_DASH2,
    PH_D0, PH_D1, PH_T, PH_H0, PH_H1, PH_COLON1, PH_MI0, PH_MI1,
    PH_COLON2, PH_S0, PH_S1, PH_AFTER_SEC, PH_FRAC_FIRST, PH_FRAC_MORE,
    PH_DONE
  } isots_phase_t;

  typedef enum logic [3:0] {
    ERR_NONE, ERR_YEAR, ERR_DASH, ERR_MONTH, ERR_DAY, ERR_T, ERR_HOUR,
    ERR_COLON, ERR_MINUTE, ERR_SECOND, ERR_EMPTY_FRAC, ERR_Z,
    ERR_TRAILING, ERR_RANGE
  } isots_err_t;

  typedef enum logic [2:0] {
    FLD_NONE, FLD_YEAR_HI, FLD_YEAR_LO, FLD_MONTH, FLD_DAY, FLD_HOUR,
    FLD_MINUTE, FLD_SECOND
  } isots_field_t;

  localparam int FRAC_W = 30;
  localparam int DAYS_W = 24;
  localparam int TOD_W  = 19;
  localparam int SECS_W = 41;
  localparam int SPLIT  = 20;
  localparam int PLO_W  = 50;
  localparam int PHI_W  = 64 - SPLIT;
  localparam int TS_W   = 64;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] FRAC_DIGITS = 4'd9;
  localparam logic [3:0] FRAC_SAT    = 4'd10;

  localparam logic [6:0] MAX_HOUR = 7'd23;
  localparam logic [6:0] MAX_MS   = 7'd59;

  // days-from-civil constants, year split as 100*h + l
  localparam logic [DAYS_W-1:0] DAYS_PER_CENT = 24'd36524;
  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 24'd365;
  localparam logic [DAYS_W-1:0] EPOCH_OFFSET  = 24'd719469;
  localparam logic [TOD_W-1:0]  SEC_PER_HOUR  = 19'd3600;
  localparam logic [TOD_W-1:0]  SEC_PER_MIN   = 19'd60;
  localparam logic [SECS_W-1:0] SEC_PER_DAY   = 41'd86400;
  localparam logic [FRAC_W-1:0] NS_PER_SEC    = 30'd1000000000;

  // one parsed string as it leaves the front end
  typedef struct packed {
    isots_err_t  err;
    logic [6:0]  year_hi;
    logic [6:0]  year_lo;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [FRAC_W-1:0] frac;
  } isots_rec_t;

  typedef struct packed {
    logic            ok;
    isots_err_t      err;
    logic [TS_W-1:0] ts;
  } isots_res_t;

endpackage

FILE: design/isots_fifo.sv
// ----------------------------------------------------------------------------
// isots_fifo
// small register queue with count, used behind the front and behind the back end
// ----------------------------------------------------------------------------
module isots_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: design/isots_front.sv
// ----------------------------------------------------------------------------
// isots_front
// per-byte syntax check and digit accumulation, one record per string
// ----------------------------------------------------------------------------
module isots_front
  import isots_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] char_byte,
  input  logic       last_byte,
  output logic       rec_push,
  output isots_rec_t rec
);

  typedef struct packed {
    logic         layout;
    logic         digit;
    logic [7:0]   ch;
    isots_err_t   err;
    isots_field_t field;
  } slot_t;

  function automatic slot_t slot_of(isots_phase_t ph);
    slot_t s;
    s = '{layout: 1'b1, digit: 1'b1, ch: 8'h00, err: ERR_YEAR, field: FLD_NONE};
    unique case (ph)
      PH_Y0, PH_Y1: s.field = FLD_YEAR_HI;
      PH_Y2, PH_Y3: s.field = FLD_YEAR_LO;
      PH_DASH1, PH_DASH2: begin
        s.digit = 1'b0;
        s.ch    = CH_DASH;
        s.err   = ERR_DASH;
      end
      PH_MO0, PH_MO1: begin
        s.err   = ERR_MONTH;
        s.field = FLD_MONTH;
      end
      PH_D0, PH_D1: begin
        s.err   = ERR_DAY;
        s.field = FLD_DAY;
      end
      PH_T: begin
        s.digit = 1'b0;
        s.ch    = CH_T;
        s.err   = ERR_T;
      end
      PH_H0, PH_H1: begin
        s.err   = ERR_HOUR;
        s.field = FLD_HOUR;
      end
      PH_COLON1, PH_COLON2: begin
        s.digit = 1'b0;
        s.ch    = CH_COLON;
        s.err   = ERR_COLON;
      end
      PH_MI0, PH_MI1: begin
        s.err   = ERR_MINUTE;
        s.field = FLD_MINUTE;
      end
      PH_S0, PH_S1: begin
        s.err   = ERR_SECOND;
        s.field = FLD_SECOND;
      end
      default: begin
        s.layout = 1'b0;
        s.digit  = 1'b0;
        s.err    = ERR_NONE;
      end
    endcase
    return s;
  endfunction

  function automatic logic [26:0] frac_weight(logic [3:0] idx);
    logic [26:0] w;
    unique case (idx)
      4'd0:    w = 27'd100000000;
      4'd1:    w = 27'd10000000;
      4'd2:    w = 27'd1000000;
      4'd3:    w = 27'd100000;
      4'd4:    w = 27'd10000;
      4'd5:    w = 27'd1000;
      4'd6:    w = 27'd100;
      4'd7:    w = 27'd10;
      4'd8:    w = 27'd1;
      default: w = 27'd0;
    endcase
    return w;
  endfunction

  isots_phase_t phase_r, phase_nxt, phase_take;
  isots_rec_t   acc_r, acc_nxt, acc_take;
  logic [3:0]   fdig_r, fdig_nxt, fdig_take;
  isots_err_t   err_take, end_err;
  slot_t        cur, after;
  logic         is_dig, in_frac, take_digit, take_frac;
  logic [3:0]   dval;

  assign is_dig  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign dval    = char_byte[3:0];
  assign in_frac = (phase_r == PH_FRAC_FIRST) || (phase_r == PH_FRAC_MORE);

  // next state
  always_comb begin
    phase_take = phase_r;
    err_take   = acc_r.err;
    if (acc_r.err == ERR_NONE) begin
      if (cur.layout) begin
        if (cur.digit ? !is_dig : (char_byte != cur.ch)) begin
          err_take = cur.err;
        end else begin
          phase_take = isots_phase_t'(phase_r + 5'd1);
        end
      end else begin
        unique case (phase_r)
          PH_AFTER_SEC: begin
            priority if (char_byte == CH_DOT) phase_take = PH_FRAC_FIRST;
            else if (char_byte == CH_Z)       phase_take = PH_DONE;
            else                              err_take   = ERR_Z;
          end
          PH_FRAC_FIRST, PH_FRAC_MORE: begin
            priority if (is_dig)               phase_take = PH_FRAC_MORE;
            else if (phase_r == PH_FRAC_FIRST) err_take   = ERR_EMPTY_FRAC;
            else if (char_byte == CH_Z)        phase_take = PH_DONE;
            else                               err_take   = ERR_Z;
          end
          default: err_take = ERR_TRAILING;
        endcase
      end
    end
    phase_nxt = take ? (last_byte ? PH_Y0 : phase_take) : phase_r;
  end

  // outputs: slot decode, end-of-string error and the record
  always_comb begin
    cur   = slot_of(phase_r);
    after = slot_of(phase_take);
    if (after.layout) begin
      end_err = after.err;
    end else begin
      unique case (phase_take)
        PH_FRAC_FIRST: end_err = ERR_EMPTY_FRAC;
        PH_DONE:       end_err = ERR_NONE;
        default:       end_err = ERR_Z;
      endcase
    end
    rec      = acc_take;
    rec.err  = (err_take != ERR_NONE) ? err_take : end_err;
    rec_push = take && last_byte;
  end

  // digit accumulation
  always_comb begin
    take_digit = (acc_r.err == ERR_NONE) && cur.layout && cur.digit && is_dig;
    take_frac  = (acc_r.err == ERR_NONE) && in_frac && is_dig;
    acc_take     = acc_r;
    acc_take.err = err_take;
    fdig_take    = fdig_r;
    if (take_digit) begin
      unique case (cur.field)
        FLD_YEAR_HI: acc_take.year_hi = acc_r.year_hi * 7'd10 + {3'b000, dval};
        FLD_YEAR_LO: acc_take.year_lo = acc_r.year_lo * 7'd10 + {3'b000, dval};
        FLD_MONTH:   acc_take.month   = acc_r.month * 7'd10 + {3'b000, dval};
        FLD_DAY:     acc_take.day     = acc_r.day * 7'd10 + {3'b000, dval};
        FLD_HOUR:    acc_take.hour    = acc_r.hour * 7'd10 + {3'b000, dval};
        FLD_MINUTE:  acc_take.minute  = acc_r.minute * 7'd10 + {3'b000, dval};
        FLD_SECOND:  acc_take.second  = acc_r.second * 7'd10 + {3'b000, dval};
        default: ;
      endcase
    end
    if (take_frac) begin
      if (fdig_r < FRAC_DIGITS) begin
        acc_take.frac = acc_r.frac
                      + FRAC_W'(dval) * FRAC_W'(frac_weight(fdig_r));
      end
      if (fdig_r < FRAC_SAT) begin
        fdig_take = fdig_r + 4'd1;
      end
    end
    acc_nxt  = take ? (last_byte ? '0 : acc_take) : acc_r;
    fdig_nxt = take ? (last_byte ? '0 : fdig_take) : fdig_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_Y0;
      acc_r   <= '0;
      fdig_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      fdig_r  <= fdig_nxt;
    end
  end

endmodule

FILE: design/isots_back.sv
// ----------------------------------------------------------------------------
// isots_back
// five-stage range check and civil-date to nanosecond conversion
// ----------------------------------------------------------------------------
module isots_back
  import isots_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  isots_rec_t rec,
  input  logic       rec_valid,
  output logic       rec_pop,
  output isots_res_t res,
  output logic       res_push,
  input  logic       res_full
);

  typedef struct packed {
    isots_err_t  err;
    logic [7:0]  h;
    logic [6:0]  l;
    logic [8:0]  doy;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [FRAC_W-1:0] frac;
  } st1_t;

  typedef struct packed {
    isots_err_t        err;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
    logic [FRAC_W-1:0] frac;
  } st2_t;

  typedef struct packed {
    isots_err_t        err;
    logic [SECS_W-1:0] secs;
    logic [FRAC_W-1:0] frac;
  } st3_t;

  typedef struct packed {
    isots_err_t        err;
    logic [PLO_W-1:0]  plo;
    logic [PHI_W-1:0]  phi;
    logic [FRAC_W-1:0] frac;
  } st4_t;

  function automatic logic [4:0] month_len(logic [6:0] mo, logic leap);
    logic [4:0] d;
    unique case (mo)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: d = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    d = 5'd30;
      7'd2:    d = leap ? 5'd29 : 5'd28;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // days before the month in a march-based year
  function automatic logic [8:0] march_days(logic [6:0] mo);
    logic [8:0] d;
    unique case (mo)
      7'd1:    d = 9'd306;
      7'd2:    d = 9'd337;
      7'd4:    d = 9'd31;
      7'd5:    d = 9'd61;
      7'd6:    d = 9'd92;
      7'd7:    d = 9'd122;
      7'd8:    d = 9'd153;
      7'd9:    d = 9'd184;
      7'd10:   d = 9'd214;
      7'd11:   d = 9'd245;
      7'd12:   d = 9'd275;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  logic       v1_r, v2_r, v3_r, v4_r, v5_r;
  st1_t       s1_r, s1_nxt;
  st2_t       s2_r, s2_nxt;
  st3_t       s3_r, s3_nxt;
  st4_t       s4_r, s4_nxt;
  isots_res_t s5_r, s5_nxt;
  logic       adv, leap, fields_ok;
  logic [4:0] dim;
  logic [DAYS_W-1:0] h_ext;

  assign adv      = !v5_r || !res_full;
  assign rec_pop  = adv && rec_valid;
  assign res_push = v5_r && !res_full;
  assign res      = s5_r;

  // stage 1: range check, march-based year split
  always_comb begin
    leap = ((rec.year_lo != 7'd0) && (rec.year_lo[1:0] == 2'b00))
        || ((rec.year_lo == 7'd0) && (rec.year_hi[1:0] == 2'b00));
    dim  = month_len(rec.month, leap);
    fields_ok = (rec.month >= 7'd1) && (rec.month <= 7'd12)
             && (rec.hour <= MAX_HOUR) && (rec.minute <= MAX_MS)
             && (rec.second <= MAX_MS)
             && (rec.day >= 7'd1) && (rec.day <= {2'b00, dim});
    s1_nxt.err = (rec.err != ERR_NONE) ? rec.err
               : (fields_ok ? ERR_NONE : ERR_RANGE);
    // jan and feb belong to the previous march-based year
    priority if (rec.month > 7'd2) begin
      s1_nxt.h = {1'b0, rec.year_hi};
      s1_nxt.l = rec.year_lo;
    end else if (rec.year_lo != 7'd0) begin
      s1_nxt.h = {1'b0, rec.year_hi};
      s1_nxt.l = rec.year_lo - 7'd1;
    end else begin
      s1_nxt.h = {1'b0, rec.year_hi} - 8'd1;
      s1_nxt.l = 7'd99;
    end
    s1_nxt.doy    = march_days(rec.month) + {2'b00, rec.day};
    s1_nxt.hour   = rec.hour;
    s1_nxt.minute = rec.minute;
    s1_nxt.second = rec.second;
    s1_nxt.frac   = rec.frac;
  end

  // stage 2: day count and time of day
  always_comb begin
    h_ext = {{(DAYS_W - 8){s1_r.h[7]}}, s1_r.h};
    s2_nxt.err  = s1_r.err;
    s2_nxt.days = h_ext * DAYS_PER_CENT
                + {{2{h_ext[DAYS_W-1]}}, h_ext[DAYS_W-1:2]}
                + DAYS_W'(s1_r.l) * DAYS_PER_YEAR
                + DAYS_W'(s1_r.l[6:2])
                + DAYS_W'(s1_r.doy)
                - EPOCH_OFFSET;
    s2_nxt.tod  = TOD_W'(s1_r.hour) * SEC_PER_HOUR
                + TOD_W'(s1_r.minute) * SEC_PER_MIN
                + TOD_W'(s1_r.second);
    s2_nxt.frac = s1_r.frac;
  end

  // stage 3: seconds
  always_comb begin
    s3_nxt.err  = s2_r.err;
    s3_nxt.secs = {{(SECS_W - DAYS_W){s2_r.days[DAYS_W-1]}}, s2_r.days} * SEC_PER_DAY
                + SECS_W'(s2_r.tod);
    s3_nxt.frac = s2_r.frac;
  end

  // stage 4: partial products of seconds times 1e9
  always_comb begin
    s4_nxt.err  = s3_r.err;
    s4_nxt.plo  = PLO_W'(s3_r.secs[SPLIT-1:0]) * PLO_W'(NS_PER_SEC);
    s4_nxt.phi  = {{(PHI_W - SECS_W + SPLIT){s3_r.secs[SECS_W-1]}},
                   s3_r.secs[SECS_W-1:SPLIT]} * PHI_W'(NS_PER_SEC);
    s4_nxt.frac = s3_r.frac;
  end

  // stage 5: sum, zero on error
  always_comb begin
    s5_nxt.ok  = (s4_r.err == ERR_NONE);
    s5_nxt.err = s4_r.err;
    s5_nxt.ts  = '0;
    if (s4_r.err == ERR_NONE) begin
      s5_nxt.ts = {s4_r.phi, {SPLIT{1'b0}}} + TS_W'(s4_r.plo) + TS_W'(s4_r.frac);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= rec_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

endmodule

FILE: design/iso8601_timestamp_parser_unit.sv
// ----------------------------------------------------------------------------
// iso8601_timestamp_parser_unit
// throughput: one byte per cycle while the record queue has room; a string
// of n bytes gives one result, which passes the record queue, five conversion
// stages and a result queue write on its way to the out ports
// reset: synchronous, active low; empties both queues, front starts at year
// ----------------------------------------------------------------------------
module iso8601_timestamp_parser_unit
  import isots_pkg::*;
#(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input side
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_char_byte,
  input  logic               in_last_byte,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic               out_ok,
  output logic [3:0]         out_error_code,
  output logic signed [63:0] out_timestamp_ns
);

  // byte transfer into the front parser
  logic       in_take;
  // front to record queue
  logic       rec_push;
  isots_rec_t front_rec;
  // record queue to back end
  logic [$bits(isots_rec_t)-1:0] mid_dout;
  isots_rec_t mid_rec;
  logic       mid_full, mid_empty, mid_pop;
  // back end to result queue
  isots_res_t back_res;
  logic       res_push, res_full;
  // result queue head
  logic [$bits(isots_res_t)-1:0] out_dout;
  isots_res_t out_res;
  logic       out_take;

  // the front only blocks when the record queue has no room
  assign full     = mid_full;
  assign in_take  = push && !full;
  assign out_take = pop && !empty;

  // front: per-byte syntax check and field accumulate
  isots_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (in_take),
    .char_byte (in_char_byte),
    .last_byte (in_last_byte),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  // short queue of parsed strings, lets front and back stall on their own
  isots_fifo #(
    .WIDTH ($bits(isots_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .din   (front_rec),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  assign mid_rec = isots_rec_t'(mid_dout);

  // back: range check and conversion pipeline, stalls as a whole
  isots_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec       (mid_rec),
    .rec_valid (!mid_empty),
    .rec_pop   (mid_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // result queue, head drives the out ports
  isots_fifo #(
    .WIDTH ($bits(isots_res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_take),
    .dout  (out_dout),
    .empty (empty)
  );

  assign out_res          = isots_res_t'(out_dout);
  assign out_ok           = out_res.ok;
  assign out_error_code   = out_res.err;
  assign out_timestamp_ns = out_res.ts;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// byte-stream check of the iso-8601 utc timestamp parser: a directed table of
// strings, then random well-formed, broken and noise strings, each byte pushed
// into the parser while random pop stalls work the result queue; each result is
// compared against a typed row or a local parser and days-from-civil converter
// ----------------------------------------------------------------------------
module tb
  import isots_pkg::*;
();

  localparam int CYCLE_LIMIT      = 200000;
  localparam int DRAIN_CYCLES     = 24;
  localparam int HOLD_CYCLES      = 300;
  localparam int ITEM_TARGET      = 650;
  localparam int RANDOM_MIN_STR   = 3;
  localparam int PRESSURE_STRINGS = 18;
  localparam int REPORT_MAX       = 10;

  // scan position and fields gathered so far for the string in flight
  typedef struct packed {
    isots_phase_t ph;
    logic [13:0]  year;
    logic [6:0]   month;
    logic [6:0]   day;
    logic [6:0]   hour;
    logic [6:0]   minute;
    logic [6:0]   second;
    logic [29:0]  frac;
    logic [3:0]   ndig;
    isots_err_t   err;
  } scan_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic [7:0] in_char_byte = 8'h00;
  logic in_last_byte = 1'b0;
  logic full;
  logic empty;
  logic out_ok;
  logic [3:0] out_error_code;
  logic signed [63:0] out_timestamp_ns;

  scan_state_t scan = '0;
  isots_res_t pending_stamps[$];
  logic [7:0] text_buf[$];

  // directed table, one string per row, typed result where it is obvious
  string dir_text[$];
  bit dir_typed[$];
  isots_res_t dir_res[$];

  bit typed_valid = 1'b0;
  isots_res_t typed_res = '0;
  bit pop_hold_req = 1'b0;
  int mismatch_count = 0;
  int cycle_count = 0;

  iso8601_timestamp_parser_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_char_byte     (in_char_byte),
    .in_last_byte     (in_last_byte),
    .empty            (empty),
    .pop              (pop),
    .out_ok           (out_ok),
    .out_error_code   (out_error_code),
    .out_timestamp_ns (out_timestamp_ns)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- parsing

  // fixed character of a separator slot, zero where a digit belongs
  function automatic logic [7:0] slot_literal(input isots_phase_t p);
    case (p)
      PH_DASH1, PH_DASH2:     return CH_DASH;
      PH_T:                   return CH_T;
      PH_COLON1, PH_COLON2:   return CH_COLON;
      default:                return 8'h00;
    endcase
  endfunction

  // error for a wrong byte at this slot, and also for a string ending here
  function automatic isots_err_t slot_error(input isots_phase_t p);
    case (p)
      PH_Y0, PH_Y1, PH_Y2, PH_Y3: return ERR_YEAR;
      PH_DASH1, PH_DASH2:         return ERR_DASH;
      PH_MO0, PH_MO1:             return ERR_MONTH;
      PH_D0, PH_D1:               return ERR_DAY;
      PH_T:                       return ERR_T;
      PH_H0, PH_H1:               return ERR_HOUR;
      PH_COLON1, PH_COLON2:       return ERR_COLON;
      PH_MI0, PH_MI1:             return ERR_MINUTE;
      PH_S0, PH_S1:               return ERR_SECOND;
      PH_FRAC_FIRST:              return ERR_EMPTY_FRAC;
      PH_DONE:                    return ERR_NONE;
      default:                    return ERR_Z;
    endcase
  endfunction

  // weight in ns of the fraction digit at position n (0 is tenths)
  function automatic logic [29:0] digit_weight(input logic [3:0] n);
    logic [29:0] w;
    w = 30'd100000000;
    repeat (n) w = 30'(w / 10);
    return w;
  endfunction

  // proleptic gregorian range check of the gathered fields
  function automatic bit fields_in_range();
    bit leap;
    logic [6:0] dim;
    if (scan.month < 1 || scan.month > 12) return 1'b0;
    if (scan.hour > MAX_HOUR || scan.minute > MAX_MS || scan.second > MAX_MS) return 1'b0;
    leap = (scan.year % 4 == 0 && scan.year % 100 != 0) || scan.year % 400 == 0;
    case (scan.month)
      7'd2:                     dim = leap ? 7'd29 : 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:  dim = 7'd30;
      default:                  dim = 7'd31;
    endcase
    return scan.day >= 1 && scan.day <= dim;
  endfunction

  // days-from-civil, then seconds and ns, all wrapping at 64 bits
  function automatic logic [63:0] civil_ns();
    longint y, era, yoe, mp, doy, doe, days, secs;
    y    = longint'(scan.year) - ((scan.month <= 2) ? 1 : 0);
    era  = ((y >= 0) ? y : y - 399) / 400;
    yoe  = y - era * 400;
    mp   = (scan.month > 2) ? longint'(scan.month) - 3 : longint'(scan.month) + 9;
    doy  = (153 * mp + 2) / 5 + longint'(scan.day) - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    secs = days * 86400 + longint'(scan.hour) * 3600 + longint'(scan.minute) * 60
         + longint'(scan.second);
    return 64'(secs) * 64'd1000000000 + 64'(scan.frac);
  endfunction

  // advance the scan by one byte; on the last byte return the result
  function automatic bit scan_byte(input logic [7:0] c, input bit last,
                                   output isots_res_t res);
    bit digit;
    logic [7:0] lit;
    logic [7:0] dv;
    isots_err_t code;
    digit = c >= CH_ZERO && c <= CH_NINE;
    dv = c - CH_ZERO;
    lit = slot_literal(scan.ph);
    res = '0;
    // once an error is kept the bytes up to the last one are ignored
    if (scan.err == ERR_NONE) begin
      if (scan.ph < PH_AFTER_SEC) begin
        if ((lit == 8'h00) ? !digit : (c != lit)) begin
          scan.err = slot_error(scan.ph);
        end else begin
          case (scan.ph)
            PH_Y0, PH_Y1, PH_Y2, PH_Y3: scan.year   = 14'(scan.year * 10 + dv);
            PH_MO0, PH_MO1:             scan.month  = 7'(scan.month * 10 + dv);
            PH_D0, PH_D1:               scan.day    = 7'(scan.day * 10 + dv);
            PH_H0, PH_H1:               scan.hour   = 7'(scan.hour * 10 + dv);
            PH_MI0, PH_MI1:             scan.minute = 7'(scan.minute * 10 + dv);
            PH_S0, PH_S1:               scan.second = 7'(scan.second * 10 + dv);
            default: ;
          endcase
          scan.ph = isots_phase_t'(scan.ph + 1);
        end
      end else if (scan.ph == PH_AFTER_SEC) begin
        if (c == CH_DOT) scan.ph = PH_FRAC_FIRST;
        else if (c == CH_Z) scan.ph = PH_DONE;
        else scan.err = ERR_Z;
      end else if (scan.ph == PH_FRAC_FIRST || scan.ph == PH_FRAC_MORE) begin
        if (digit) begin
          // only nine digits weigh in, the count saturates past them
          if (scan.ndig < FRAC_DIGITS)
            scan.frac = 30'(scan.frac + dv * digit_weight(scan.ndig));
          if (scan.ndig < FRAC_SAT) scan.ndig = scan.ndig + 4'd1;
          scan.ph = PH_FRAC_MORE;
        end else if (scan.ph == PH_FRAC_FIRST) begin
          scan.err = ERR_EMPTY_FRAC;
        end else if (c == CH_Z) begin
          scan.ph = PH_DONE;
        end else begin
          scan.err = ERR_Z;
        end
      end else begin
        scan.err = ERR_TRAILING;
      end
    end
    if (!last) return 1'b0;
    // a string cut short reports the item that was due next
    code = (scan.err != ERR_NONE) ? scan.err : slot_error(scan.ph);
    if (code == ERR_NONE && !fields_in_range()) code = ERR_RANGE;
    res.ok  = code == ERR_NONE;
    res.err = code;
    res.ts  = (code == ERR_NONE) ? civil_ns() : 64'd0;
    scan = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // append one byte to the string being built
  task automatic buf_add(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic add_row(input string s, input bit typed, input bit ok,
                         input isots_err_t e, input logic [63:0] ts);
    isots_res_t r;
    r.ok = ok;
    r.err = e;
    r.ts = ts;
    dir_text.insert(dir_text.size(), s);
    dir_typed.insert(dir_typed.size(), typed);
    dir_res.insert(dir_res.size(), r);
  endtask

  task automatic put_digits(input int value, input int n);
    int p;
    p = 1;
    repeat (n - 1) p = p * 10;
    repeat (n) begin
      buf_add(8'(CH_ZERO + (value / p) % 10));
      p = p / 10;
    end
  endtask

  // mostly well-formed strings with random fields, the rest broken or noise
  task automatic make_random_text();
    int kind, r, yr, mo, dy, hh, mi, ss, nfrac, pos;
    kind = $urandom_range(0, 99);
    text_buf.delete();
    if (kind < 6) begin
      repeat ($urandom_range(1, 30)) buf_add(8'($urandom_range(0, 255)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 10) yr = $urandom_range(0, 9);
    else if (r < 20) yr = $urandom_range(9990, 9999);
    else if (r < 70) yr = $urandom_range(1678, 2262);
    else yr = $urandom_range(0, 9999);
    mo = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (r < 80) dy = $urandom_range(1, 31);
    else if (r < 90) dy = $urandom_range(28, 31);
    else dy = $urandom_range(0, 99);
    hh = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 23) : $urandom_range(0, 99);
    mi = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    ss = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 59) : $urandom_range(0, 99);
    put_digits(yr, 4);
    buf_add(CH_DASH);
    put_digits(mo, 2);
    buf_add(CH_DASH);
    put_digits(dy, 2);
    buf_add(CH_T);
    put_digits(hh, 2);
    buf_add(CH_COLON);
    put_digits(mi, 2);
    buf_add(CH_COLON);
    put_digits(ss, 2);
    if ($urandom_range(0, 99) >= 30) begin
      buf_add(CH_DOT);
      nfrac = $urandom_range(0, 12);
      repeat (nfrac) buf_add(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    buf_add(CH_Z);
    if (kind >= 70) begin
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 3))
        0: text_buf[pos] = 8'($urandom_range(0, 255));
        1: while (text_buf.size() > pos + 1) void'(text_buf.pop_back());
        2: repeat ($urandom_range(1, 3)) buf_add(8'($urandom_range(0, 255)));
        default: text_buf.insert(pos, 8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  // offer one byte, wait for the transfer, then record what it predicts
  task automatic send_byte(input logic [7:0] c, input bit last, input int gap);
    isots_res_t res;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_char_byte <= c;
    in_last_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    if (scan_byte(c, last, res))
      pending_stamps.insert(pending_stamps.size(), typed_valid ? typed_res : res);
  endtask

  task automatic send_text(input bit burst);
    int k;
    for (k = 0; k < text_buf.size(); k++)
      send_byte(text_buf[k], k == text_buf.size() - 1, burst ? 0 : idle_len());
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_result();
    isots_res_t want;
    if (pending_stamps.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("unexpected result: ok=%0b err=%0d ts=%0d",
                 out_ok, out_error_code, out_timestamp_ns);
      return;
    end
    want = pending_stamps.pop_front();
    if (out_ok !== want.ok || out_error_code !== want.err || out_timestamp_ns !== want.ts) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("mismatch: expected ok=%0b err=%0d ts=%0d, got ok=%0b err=%0d ts=%0d",
                 want.ok, want.err, $signed(want.ts),
                 out_ok, out_error_code, out_timestamp_ns);
    end
  endtask

  // result side: random pop stalls, steady stretches, one long hold-off
  initial begin : result_side
    int stall_left;
    int steady_left;
    bit steady;
    stall_left = 0;
    steady_left = $urandom_range(50, 300);
    steady = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_result();
      if (steady_left == 0) begin
        steady = ~steady;
        steady_left = $urandom_range(50, 300);
      end else begin
        steady_left--;
      end
      if (pop_hold_req) begin
        // long hold-off so both queues fill and the input backs up
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pop_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // run time guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- main

  initial begin : main_seq
    int i;
    int k;
    int sent_bytes;
    int random_strings;
    sent_bytes = 0;
    random_strings = 0;

    // extremes of the representable range and the epoch
    add_row("1970-01-01T00:00:00Z", 1, 1, ERR_NONE, 64'd0);
    add_row("1970-01-01T00:00:00.000000001Z", 1, 1, ERR_NONE, 64'd1);
    add_row("2262-04-11T23:47:16.854775807Z", 1, 1, ERR_NONE, 64'h7FFF_FFFF_FFFF_FFFF);
    add_row("1677-09-21T00:12:43.145224192Z", 1, 1, ERR_NONE, 64'h8000_0000_0000_0000);
    // wrapped years, year zero as leap year, fraction past nine digits
    add_row("0000-01-01T00:00:00Z", 0, 0, ERR_NONE, 64'd0);
    add_row("0000-02-29T00:00:00Z", 0, 0, ERR_NONE, 64'd0);
    add_row("9999-12-31T23:59:59.999999999999Z", 0, 0, ERR_NONE, 64'd0);
    add_row("2000-02-29T12:34:56.5Z", 0, 0, ERR_NONE, 64'd0);
    // field out of range
    add_row("2100-02-29T00:00:00Z", 1, 0, ERR_RANGE, 64'd0);
    add_row("2023-13-01T00:00:00Z", 1, 0, ERR_RANGE, 64'd0);
    add_row("2023-01-00T00:00:00Z", 1, 0, ERR_RANGE, 64'd0);
    add_row("2023-01-01T24:00:00Z", 1, 0, ERR_RANGE, 64'd0);
    add_row("2023-01-01T00:60:60Z", 1, 0, ERR_RANGE, 64'd0);
    // wrong byte at each slot, first error kept
    add_row("19a0-01-01T00:00:00Z", 1, 0, ERR_YEAR, 64'd0);
    add_row("1970/01-01T00:00:00Z", 1, 0, ERR_DASH, 64'd0);
    add_row("1970-1x-01T00:00:00Z", 1, 0, ERR_MONTH, 64'd0);
    add_row("1970-01-x1T00:00:00Z", 1, 0, ERR_DAY, 64'd0);
    add_row("1970-01-01 00:00:00Z", 1, 0, ERR_T, 64'd0);
    add_row("1970-01-01T0:00:00Z", 1, 0, ERR_HOUR, 64'd0);
    add_row("1970-01-01T00.00:00Z", 1, 0, ERR_COLON, 64'd0);
    add_row("1970-01-01T00:0a:00Z", 1, 0, ERR_MINUTE, 64'd0);
    add_row("1970-01-01T00:00:5Z", 1, 0, ERR_SECOND, 64'd0);
    add_row("1970-01-01T00:00:00+00", 1, 0, ERR_Z, 64'd0);
    add_row("1970-01-01T00:00:00.Z", 1, 0, ERR_EMPTY_FRAC, 64'd0);
    add_row("1970-01-01T00:00:00.12x", 1, 0, ERR_Z, 64'd0);
    add_row("1970-01-01T00:00:00Z ", 1, 0, ERR_TRAILING, 64'd0);
    // strings that end early
    add_row("1", 1, 0, ERR_YEAR, 64'd0);
    add_row("1970", 1, 0, ERR_DASH, 64'd0);
    add_row("1970-01-01T00:00:00", 1, 0, ERR_Z, 64'd0);
    add_row("1970-01-01T00:00:00.", 1, 0, ERR_EMPTY_FRAC, 64'd0);
    add_row("1970-01-01T00:00:00.25", 1, 0, ERR_Z, 64'd0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (i = 0; i < dir_text.size(); i++) begin
      typed_valid = dir_typed[i];
      typed_res = dir_res[i];
      text_buf.delete();
      for (k = 0; k < dir_text[i].len(); k++) buf_add(dir_text[i][k]);
      sent_bytes += text_buf.size();
      send_text(1'b0);
    end
    typed_valid = 1'b0;

    // back-pressure episode: short noise strings while results are held off
    pop_hold_req = 1'b1;
    repeat (PRESSURE_STRINGS) begin
      text_buf.delete();
      repeat ($urandom_range(1, 2)) buf_add(8'($urandom_range(0, 255)));
      sent_bytes += text_buf.size();
      send_text(1'b1);
    end

    // random strings up to the byte budget
    while (sent_bytes < ITEM_TARGET || random_strings < RANDOM_MIN_STR) begin
      make_random_text();
      sent_bytes += text_buf.size();
      random_strings++;
      send_text($urandom_range(0, 3) == 0);
    end
    push <= 1'b0;

    // drain, then keep watching to catch any stray result
    while (pending_stamps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_stamps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
